// ===== rtl/header_line_unfolding_parser_macros.svh =====
// Assertion macros used by the header line parser checker.
`ifndef HEADER_LINE_UNFOLDING_PARSER_MACROS_SVH
`define HEADER_LINE_UNFOLDING_PARSER_MACROS_SVH

// Same-cycle implication: cond holds, so must prop.
`define HLUP_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication: cond holds, so prop holds in the next cycle.
`define HLUP_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== rtl/hlup_pkg.sv =====
// Constants and codes shared by the header line parser and its checker.
package hlup_pkg;

	localparam int LENGTH_BITS = 16;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_NAME  = 2'd1;
	localparam logic [1:0] KIND_VALUE = 2'd2;

	localparam logic [1:0] LE_NONE  = 2'd0;
	localparam logic [1:0] LE_DONE  = 2'd1;
	localparam logic [1:0] LE_BLANK = 2'd2;
	localparam logic [1:0] LE_ERR   = 2'd3;

	localparam logic [2:0] PH_NAME     = 3'd0;
	localparam logic [2:0] PH_NAME_CR  = 3'd1;
	localparam logic [2:0] PH_SKIP     = 3'd2;
	localparam logic [2:0] PH_VALUE    = 3'd3;
	localparam logic [2:0] PH_VAL_CR   = 3'd4;
	localparam logic [2:0] PH_VAL_CRLF = 3'd5;
	localparam logic [2:0] PH_FOLD     = 3'd6;

endpackage

// ===== rtl/header_line_unfolding_parser.sv =====
// Header line parser with line unfolding: one text byte in, one result word out.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata[7:0]  data_byte
//  m_*      out  m_tvalid/m_tready  m_tuser[1:0] out_kind; m_tdata out_byte, line_end,
//                                   line_length
//
// Every accepted byte yields exactly one result word, in the cycle after acceptance.
// Throughput is one byte per cycle unless m stalls: the phase and line-count update
// is a single compare-and-select step from the input byte to the output register.
// arst_n clears the phase to the name phase, the line count to zero and m_tvalid.
// A stalled m side holds the result word; s_tready drops only while a word waits
// and m_tready is low, so a new byte enters in the same cycle the old word leaves.
module header_line_unfolding_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] out_byte, [9:8] line_end, [25:10] line_length,
	                               // [31:26] zero
	output logic [1:0]  m_tuser    // [1:0] out_kind
);

	localparam int LB = hlup_pkg::LENGTH_BITS;

	// Parser state
	logic [2:0]    phase_q;
	logic [LB-1:0] cnt_q;

	// Next-state and result terms
	logic [2:0]    ph_eff;
	logic [2:0]    nxt_phase;
	logic [LB-1:0] cnt_inc;
	logic [LB-1:0] nxt_cnt;
	logic          proc;
	logic          to_value;
	logic          is_blank;
	logic          is_sep;
	logic [1:0]    kind;
	logic [7:0]    ob;
	logic [1:0]    le;
	logic [15:0]   len;
	logic          s_acc;

	// Clamp a line count to the 16-bit report field.
	function automatic logic [15:0] clamp_len(input logic [LB-1:0] c);
		logic [31:0] v;
		v = 32'(c);
		return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
	endfunction

	assign s_tready = !m_tvalid || m_tready;
	assign s_acc    = s_tvalid && s_tready;

	assign is_blank = (s_tdata == hlup_pkg::CH_SPACE) || (s_tdata == hlup_pkg::CH_TAB);
	assign is_sep   = is_blank || (s_tdata == hlup_pkg::CH_COLON);

	// Saturating increment: the count sticks at all ones.
	assign cnt_inc = (cnt_q == {LB{1'b1}}) ? cnt_q : cnt_q + LB'(1);

	always_comb begin
		kind      = hlup_pkg::KIND_NONE;
		ob        = 8'h00;
		le        = hlup_pkg::LE_NONE;
		len       = 16'h0000;
		nxt_phase = phase_q;
		nxt_cnt   = cnt_inc;
		ph_eff    = phase_q;
		proc      = 1'b1;
		to_value  = 1'b0;

		// First, resolve the phases that wait on the byte after a CR or a CR LF.
		unique case (phase_q)
			hlup_pkg::PH_NAME_CR, hlup_pkg::PH_VAL_CR: begin
				if (s_tdata == hlup_pkg::CH_LF) begin
					proc = 1'b0;
					if (phase_q == hlup_pkg::PH_NAME_CR) begin
						// Blank or name-only line: report it with the LF counted.
						le        = hlup_pkg::LE_BLANK;
						len       = clamp_len(cnt_inc);
						nxt_cnt   = '0;
						nxt_phase = hlup_pkg::PH_NAME;
					end else begin
						nxt_phase = hlup_pkg::PH_VAL_CRLF;
					end
				end else begin
					// Lone CR: flag it and restart this byte as a new line.
					le      = hlup_pkg::LE_ERR;
					len     = clamp_len(cnt_q);
					nxt_cnt = LB'(1);
					ph_eff  = hlup_pkg::PH_NAME;
				end
			end
			hlup_pkg::PH_VAL_CRLF: begin
				if (is_blank) begin
					// Fold: the blank run collapses into one space.
					proc      = 1'b0;
					kind      = hlup_pkg::KIND_VALUE;
					ob        = hlup_pkg::CH_SPACE;
					nxt_phase = hlup_pkg::PH_FOLD;
				end else begin
					// Header done; this byte opens the next line.
					le      = hlup_pkg::LE_DONE;
					len     = clamp_len(cnt_q);
					nxt_cnt = LB'(1);
					ph_eff  = hlup_pkg::PH_NAME;
				end
			end
			hlup_pkg::PH_NAME, hlup_pkg::PH_SKIP, hlup_pkg::PH_VALUE, hlup_pkg::PH_FOLD: begin
			end
			default: ph_eff = hlup_pkg::PH_NAME;
		endcase

		// Then handle the byte as part of the current line.
		if (proc) begin
			nxt_phase = ph_eff;
			unique case (ph_eff)
				hlup_pkg::PH_NAME: begin
					if (is_sep) begin
						nxt_phase = hlup_pkg::PH_SKIP;
					end else if (s_tdata == hlup_pkg::CH_CR) begin
						nxt_phase = hlup_pkg::PH_NAME_CR;
					end else begin
						kind = hlup_pkg::KIND_NAME;
						ob   = s_tdata;
					end
				end
				hlup_pkg::PH_SKIP: to_value = !is_sep;
				hlup_pkg::PH_FOLD: to_value = !is_blank;
				default:           to_value = 1'b1;
			endcase
			if (to_value) begin
				if (s_tdata == hlup_pkg::CH_CR) begin
					nxt_phase = hlup_pkg::PH_VAL_CR;
				end else begin
					kind      = hlup_pkg::KIND_VALUE;
					ob        = s_tdata;
					nxt_phase = hlup_pkg::PH_VALUE;
				end
			end
		end
	end

	// Advance state on every accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hlup_pkg::PH_NAME;
			cnt_q   <= '0;
		end else if (s_acc) begin
			phase_q <= nxt_phase;
			cnt_q   <= nxt_cnt;
		end
	end

	// Output register valid: set on accept, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s_acc) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// Output payload: load with each accepted byte, hold otherwise.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			m_tdata <= {6'd0, len, le, ob};
			m_tuser <= kind;
		end
	end

endmodule

// ===== rtl/hlup_checker.sv =====
// Port-level checker for the header line parser, bound to the top level.
`include "header_line_unfolding_parser_macros.svh"

module hlup_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);

	`HLUP_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled word changed")
	`HLUP_ASSERT_NEXT(a_one_result, clk, arst_n, s_tvalid && s_tready, m_tvalid, "accepted byte gave no word")
	`HLUP_ASSERT_NOW(a_kind_code, clk, arst_n, m_tvalid, m_tuser <= hlup_pkg::KIND_VALUE, "unused kind code")
	`HLUP_ASSERT_NOW(a_empty_byte, clk, arst_n, m_tvalid && (m_tuser == hlup_pkg::KIND_NONE), m_tdata[7:0] == 8'h00, "byte set with nothing emitted")
	`HLUP_ASSERT_NOW(a_empty_len, clk, arst_n, m_tvalid && (m_tdata[9:8] == hlup_pkg::LE_NONE), m_tdata[25:10] == 16'h0000, "length set without line end")

endmodule

bind header_line_unfolding_parser hlup_checker u_hlup_checker (.*);
